@@ rtl/rcfp_pkg.sv @@
// Shared types and constants for the channel frame parser.
// No dependencies; imported by every other file of the block.
package rcfp_pkg;

    localparam int FRAME_LEN    = 20;
    localparam int STORE_LEN    = FRAME_LEN - 1;
    localparam int NUM_CHANNELS = 16;
    localparam int ADDR_W       = 5;
    localparam int CH_W         = 4;
    localparam int VAL_W        = 13;
    localparam int NEU_W        = 12;
    localparam int ACC_W        = 14;

    localparam logic [7:0]       END_MARK      = 8'h23;
    localparam logic [NEU_W-1:0] NEUTRAL_RESET = 12'd1500;
    localparam logic [VAL_W-1:0] DEG_OFFSET    = 13'd127;
    localparam logic [ACC_W-1:0] PULSE_MAX     = 14'd3000;

    localparam logic [7:0] ASC_H     = 8'h48;
    localparam logic [7:0] ASC_E     = 8'h45;
    localparam logic [7:0] ASC_X     = 8'h58;
    localparam logic [7:0] ASC_D     = 8'h44;
    localparam logic [7:0] ASC_G     = 8'h47;
    localparam logic [7:0] ASC_S     = 8'h53;
    localparam logic [7:0] ASC_R     = 8'h52;
    localparam logic [7:0] ASC_V     = 8'h56;
    localparam logic [7:0] ASC_T     = 8'h54;
    localparam logic [7:0] ASC_8     = 8'h38;
    localparam logic [7:0] ASC_L     = 8'h4C;
    localparam logic [7:0] ASC_PLUS  = 8'h2B;
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_0     = 8'h30;
    localparam logic [7:0] ASC_9     = 8'h39;

    // configuration register indexes
    localparam logic REG_NEUTRAL = 1'b0;

    typedef enum logic [2:0] {
        K_HEX = 3'd0,
        K_DEG = 3'd1,
        K_SRV = 3'd2,
        K_SS8 = 3'd3,
        K_LED = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_CHAN,
        S_BYTE,
        S_EMIT
    } t_dec_state;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [VAL_W-1:0] value;
        t_kind            kind;
        logic             last;
    } t_result;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_mem_rd;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

endpackage

@@ rtl/rcfp_store.sv @@
// Frame byte store: one write port, one read port, registered read data.
// Depends on rcfp_pkg.
module rcfp_store (
    input  logic             i_clk,
    input  rcfp_pkg::t_mem_wr i_wr,
    input  rcfp_pkg::t_mem_rd i_rd,
    output logic [7:0]        o_rd_data
);
    import rcfp_pkg::*;

    logic [7:0] r_mem [STORE_LEN];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/rcfp_dec.sv @@
// Frame decoder: walks the byte store one read at a time and builds
// one result per channel, or a single LED result. Depends on rcfp_pkg.
module rcfp_dec (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rcfp_pkg::NEU_W-1:0]   i_neutral,
    input  logic [7:0]                   i_rd_data,
    input  logic                         i_slot_free,
    output rcfp_pkg::t_mem_rd            o_rd,
    output logic                         o_busy,
    output logic                         o_res_valid,
    output rcfp_pkg::t_result            o_res
);
    import rcfp_pkg::*;

    typedef enum logic [1:0] {
        P_WS,
        P_DIG,
        P_STOP
    } t_phase;

    function automatic logic [3:0] nib(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] times10(input logic [7:0] x);
        logic [VAL_W-1:0] w;
        w = {5'b0, x};
        return (w << 3) + (w << 1);
    endfunction

    t_dec_state       r_state, n_state;
    logic [1:0]       r_j, n_j;
    logic [7:0]       r_h0, n_h0, r_h1, n_h1;
    t_kind            r_kind, n_kind;
    logic [CH_W-1:0]  r_ch, n_ch;
    logic [ACC_W-1:0] r_acc, n_acc;
    t_phase           r_phase, n_phase;
    logic             r_neg, n_neg;
    t_result          r_res, n_res;

    logic [2:0]        w_nbytes;
    logic [ADDR_W-1:0] w_base;
    logic              w_last_j;
    logic [7:0]        w_c;
    logic              w_sp, w_dig;
    logic [ACC_W-1:0]  f_acc;
    t_phase            f_phase;
    logic              f_neg;
    logic [VAL_W-1:0]  w_srv_val, w_byte_val;
    logic              w_hdr_ok;
    t_kind             w_hdr_kind;

    assign w_c = i_rd_data;

    // bytes per channel and where the channel's bytes start
    always_comb begin
        w_nbytes = 3'd0;
        w_base   = ADDR_W'(3);
        unique case (r_kind)
            K_HEX, K_DEG: begin
                w_nbytes = 3'd1;
                w_base   = ADDR_W'(3) + {1'b0, r_ch};
            end
            K_SS8: begin
                w_nbytes = r_ch[3] ? 3'd0 : 3'd2;
                w_base   = ADDR_W'(3) + {r_ch, 1'b0};
            end
            K_SRV: begin
                w_nbytes = (r_ch[3:2] != 2'd0) ? 3'd0 : 3'd4;
                w_base   = ADDR_W'(3) + {r_ch[2:0], 2'b00};
            end
            default: begin
                w_nbytes = 3'd0;
                w_base   = ADDR_W'(3);
            end
        endcase
    end

    assign w_last_j = ({1'b0, r_j} == (w_nbytes - 3'd1));

    // decimal group: one character per step
    assign w_sp  = (w_c == ASC_SPACE) || (w_c >= 8'd9 && w_c <= 8'd13);
    assign w_dig = (w_c >= ASC_0) && (w_c <= ASC_9);

    always_comb begin
        f_acc   = r_acc;
        f_phase = r_phase;
        f_neg   = r_neg;
        unique case (r_phase)
            P_WS: begin
                if (w_sp) begin
                    f_phase = P_WS;
                end else if (w_c == ASC_PLUS || w_c == ASC_MINUS) begin
                    f_neg   = (w_c == ASC_MINUS);
                    f_phase = P_DIG;
                end else if (w_dig) begin
                    f_acc   = {10'b0, w_c[3:0]};
                    f_phase = P_DIG;
                end else begin
                    f_phase = P_STOP;
                end
            end
            P_DIG: begin
                if (w_dig) begin
                    f_acc = (r_acc << 3) + (r_acc << 1) + {10'b0, w_c[3:0]};
                end else begin
                    f_phase = P_STOP;
                end
            end
            default: f_phase = P_STOP;
        endcase
    end

    always_comb begin
        if (f_neg) w_srv_val = '0;
        else if (f_acc > PULSE_MAX) w_srv_val = VAL_W'(PULSE_MAX);
        else w_srv_val = VAL_W'(f_acc);
    end

    always_comb begin
        unique case (r_kind)
            K_HEX:   w_byte_val = times10(w_c);
            K_DEG:   w_byte_val = {5'b0, w_c} - DEG_OFFSET;
            K_SS8:   w_byte_val = times10({r_acc[3:0], nib(w_c)});
            K_SRV:   w_byte_val = w_srv_val;
            default: w_byte_val = '0;
        endcase
    end

    // header check on the third byte as it arrives
    always_comb begin
        w_hdr_ok   = 1'b1;
        w_hdr_kind = K_HEX;
        priority if (r_h0 == ASC_H && r_h1 == ASC_E && w_c == ASC_X) begin
            w_hdr_kind = K_HEX;
        end else if (r_h0 == ASC_D && r_h1 == ASC_E && w_c == ASC_G) begin
            w_hdr_kind = K_DEG;
        end else if (r_h0 == ASC_S && r_h1 == ASC_R && (w_c == ASC_V || w_c == ASC_T)) begin
            w_hdr_kind = K_SRV;
        end else if (r_h0 == ASC_S && r_h1 == ASC_S && w_c == ASC_8) begin
            w_hdr_kind = K_SS8;
        end else if (r_h0 == ASC_L && r_h1 == ASC_E) begin
            w_hdr_kind = K_LED;
        end else begin
            w_hdr_ok = 1'b0;
        end
    end

    // next state and register updates
    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_h0    = r_h0;
        n_h1    = r_h1;
        n_kind  = r_kind;
        n_ch    = r_ch;
        n_acc   = r_acc;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_HDR;
                    n_j     = 2'd0;
                end
            end
            S_HDR: begin
                if (r_j == 2'd0) n_h0 = w_c;
                if (r_j == 2'd1) n_h1 = w_c;
                if (r_j != 2'd2) begin
                    n_j = r_j + 2'd1;
                end else if (!w_hdr_ok) begin
                    n_state = S_IDLE;
                end else if (w_hdr_kind == K_LED) begin
                    n_res   = '{channel: '0, value: '0, kind: K_LED, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_kind  = w_hdr_kind;
                    n_ch    = '0;
                    n_state = S_CHAN;
                end
            end
            S_CHAN: begin
                if (w_nbytes == 3'd0) begin
                    n_res   = '{channel: r_ch, value: {1'b0, i_neutral}, kind: r_kind,
                                last: (r_ch == CH_W'(NUM_CHANNELS - 1))};
                    n_state = S_EMIT;
                end else begin
                    n_j     = 2'd0;
                    n_acc   = '0;
                    n_phase = P_WS;
                    n_neg   = 1'b0;
                    n_state = S_BYTE;
                end
            end
            S_BYTE: begin
                n_acc   = (r_kind == K_SS8) ? {10'b0, nib(w_c)} : f_acc;
                n_phase = f_phase;
                n_neg   = f_neg;
                if (w_last_j) begin
                    n_res   = '{channel: r_ch, value: w_byte_val, kind: r_kind,
                                last: (r_ch == CH_W'(NUM_CHANNELS - 1))};
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + 2'd1;
                end
            end
            S_EMIT: begin
                if (i_slot_free) begin
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ch    = r_ch + CH_W'(1);
                        n_state = S_CHAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs: store reads and result hand-off
    always_comb begin
        o_rd        = '{en: 1'b0, addr: '0};
        o_res_valid = 1'b0;
        o_busy      = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) o_rd = '{en: 1'b1, addr: '0};
            end
            S_HDR: begin
                if (r_j != 2'd2) o_rd = '{en: 1'b1, addr: ADDR_W'(r_j) + ADDR_W'(1)};
            end
            S_CHAN: begin
                if (w_nbytes != 3'd0) o_rd = '{en: 1'b1, addr: w_base};
            end
            S_BYTE: begin
                if (!w_last_j) o_rd = '{en: 1'b1, addr: w_base + ADDR_W'(r_j) + ADDR_W'(1)};
            end
            S_EMIT: begin
                o_res_valid = i_slot_free;
            end
            default: o_rd = '{en: 1'b0, addr: '0};
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_j     <= n_j;
        r_h0    <= n_h0;
        r_h1    <= n_h1;
        r_kind  <= n_kind;
        r_ch    <= n_ch;
        r_acc   <= n_acc;
        r_phase <= n_phase;
        r_neg   <= n_neg;
        r_res   <= n_res;
    end

endmodule

@@ rtl/rc_channel_frame_parser_unit.sv @@
// Top level of the channel frame parser: byte counter, configuration port,
// output register. Depends on rcfp_pkg, rcfp_store, rcfp_dec.
//
// Received bytes enter one word per cycle while the decoder is idle and are
// kept in a 19-byte store. A '#' ends a message; when exactly 19 bytes came
// before it, the decoder reads the store back through its single read port
// and sends 16 channel words (the last with tlast) or one LED word. While
// it decodes, the input is stalled: the decoder reads the three header
// bytes, then per channel takes a setup step, one store read per byte the
// channel uses and a hand-off step that waits for a free output slot. An
// LED frame hands its word over right after the header; a header that
// matches nothing ends the stall after the header. Configuration:
// register 0 (byte address 0) holds the 12-bit neutral value, reset 1500.
module rc_channel_frame_parser_unit #(
    parameter int TEXT_LIMIT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream; tdata[7:0]: rx_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // master stream; tdata[3:0]: channel, [16:4]: value, [23:17]: zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    // tuser[2:0]: kind
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rcfp_pkg::*;

    localparam int CNT_W = $clog2(TEXT_LIMIT);

    logic [CNT_W-1:0] r_count;
    logic [NEU_W-1:0] r_neutral;
    logic             r_out_valid;
    t_result          r_out;

    logic     w_in_acc, w_is_end, w_start, w_busy, w_slot_free, w_res_valid, w_cfg_wr;
    t_mem_wr  w_wr;
    t_mem_rd  w_rd;
    logic [7:0] w_rd_data;
    t_result  w_res;

    assign s_axis_tready = !w_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_is_end      = (s_axis_tdata == END_MARK);
    assign w_start       = w_in_acc && w_is_end && (r_count == CNT_W'(STORE_LEN));

    assign w_wr = '{we:   w_in_acc && !w_is_end && (r_count < CNT_W'(STORE_LEN)),
                    addr: r_count[ADDR_W-1:0],
                    data: s_axis_tdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_in_acc) begin
            // overflowing text drops the byte and restarts the count
            if (w_is_end || r_count >= CNT_W'(TEXT_LIMIT - 1)) r_count <= '0;
            else r_count <= r_count + CNT_W'(1);
        end
    end

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == REG_NEUTRAL) ? {20'b0, r_neutral} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neutral <= NEUTRAL_RESET;
        end else if (w_cfg_wr && paddr[2] == REG_NEUTRAL) begin
            r_neutral <= pwdata[NEU_W-1:0];
        end
    end

    rcfp_store u_store (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd      (w_rd),
        .o_rd_data (w_rd_data)
    );

    rcfp_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_neutral   (r_neutral),
        .i_rd_data   (w_rd_data),
        .i_slot_free (w_slot_free),
        .o_rd        (w_rd),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // output word register
    assign w_slot_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'b0, r_out.value, r_out.channel};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for rc_channel_frame_parser_unit: byte stream in, channel words out.
// Depends on rcfp_pkg and the block's RTL; each output word is checked against the predictor or a typed row.
`timescale 1ns / 1ps

module tb_top;
    import rcfp_pkg::*;

    localparam int TEXT_LIMIT  = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE_CYC  = 100;
    localparam int HOLD_CYC    = 250;
    localparam int HOLD_AT     = 300;
    localparam int RAND_MSGS   = 100;
    localparam int NUM_ROWS    = 16;

    // one directed message: pre_len x pre_byte, then text, then pad_len x pad_byte, then '#'
    typedef struct packed {
        logic [7:0]   pre_byte;
        int           pre_len;
        logic [159:0] text;     // right-justified ASCII; leading zero bytes are unused
        logic [7:0]   pad_byte;
        int           pad_len;
        int           neutral;  // -1: leave register as is
        int           n_typed;  // -1: predictor decides; else that many words of t_val
        int           t_val;
        t_kind        t_knd;
    } t_row;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = '0;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    int unsigned      rx_count;
    logic [7:0]       msg_buf [STORE_LEN];
    logic [NEU_W-1:0] neutral_cfg;

    t_result     chan_words_q [$];   // expected words, oldest first
    t_result     fresh_words  [$];   // words predicted for the last byte
    logic [7:0]  msg_q        [$];   // bytes of the message being sent
    t_row        dir_rows     [NUM_ROWS];
    string       hex_set = "0123456789ABCDEFabcdef";

    int  err_cnt    = 0;
    int  words_seen = 0;
    int  hold_left  = 0;
    bit  hold_done  = 0;
    bit  calm       = 0;
    int  quiet      = 0;

    rc_channel_frame_parser_unit #(
        .TEXT_LIMIT(TEXT_LIMIT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic int nib_val(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return 10 + int'(c) - int'("A");
        if (c >= "a" && c <= "f") return 10 + int'(c) - int'("a");
        return 0;
    endfunction

    // four characters read as a decimal, clamped to 0..3000
    function automatic int dec_group(input int base);
        int k;
        int acc;
        bit neg;
        k   = 0;
        acc = 0;
        neg = 0;
        while (k < 4 && (msg_buf[base+k] == " " ||
               (msg_buf[base+k] >= 8'd9 && msg_buf[base+k] <= 8'd13)))
            k++;
        if (k < 4 && (msg_buf[base+k] == "+" || msg_buf[base+k] == "-")) begin
            neg = (msg_buf[base+k] == "-");
            k++;
        end
        while (k < 4 && msg_buf[base+k] >= "0" && msg_buf[base+k] <= "9") begin
            acc = acc * 10 + int'(msg_buf[base+k]) - int'("0");
            k++;
        end
        if (neg) acc = -acc;
        if (acc < 0) acc = 0;
        if (acc > int'(PULSE_MAX)) acc = int'(PULSE_MAX);
        return acc;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] c);
        int    vals [NUM_CHANNELS];
        t_kind knd;
        bit    emit16;
        knd    = K_HEX;
        emit16 = 0;
        if (c == END_MARK) begin
            if (rx_count == STORE_LEN) begin
                for (int i = 0; i < NUM_CHANNELS; i++) vals[i] = int'(neutral_cfg);
                if (msg_buf[0] == "H" && msg_buf[1] == "E" && msg_buf[2] == "X") begin
                    knd    = K_HEX;
                    emit16 = 1;
                    for (int i = 0; i < NUM_CHANNELS; i++) vals[i] = int'(msg_buf[3+i]) * 10;
                end else if (msg_buf[0] == "D" && msg_buf[1] == "E" && msg_buf[2] == "G") begin
                    knd    = K_DEG;
                    emit16 = 1;
                    for (int i = 0; i < NUM_CHANNELS; i++) vals[i] = int'(msg_buf[3+i]) - 127;
                end else if (msg_buf[0] == "S" && msg_buf[1] == "R" &&
                             (msg_buf[2] == "V" || msg_buf[2] == "T")) begin
                    knd    = K_SRV;
                    emit16 = 1;
                    for (int i = 0; i < 4; i++) vals[i] = dec_group(3 + i * 4);
                end else if (msg_buf[0] == "S" && msg_buf[1] == "S" && msg_buf[2] == "8") begin
                    knd    = K_SS8;
                    emit16 = 1;
                    for (int i = 0; i < 8; i++)
                        vals[i] = ((nib_val(msg_buf[3+i*2]) << 4) | nib_val(msg_buf[4+i*2])) * 10;
                end else if (msg_buf[0] == "L" && msg_buf[1] == "E") begin
                    fresh_words.push_back('{4'd0, 13'd0, K_LED, 1'b1});
                end
                if (emit16)
                    for (int i = 0; i < NUM_CHANNELS; i++)
                        fresh_words.push_back('{4'(i), 13'(vals[i]), knd,
                                                1'(i == NUM_CHANNELS - 1)});
            end
            rx_count = 0;
        end else if (rx_count < TEXT_LIMIT - 1) begin
            if (rx_count < STORE_LEN) msg_buf[rx_count] = c;
            rx_count++;
        end else begin
            rx_count = 0;   // overflow: byte dropped
        end
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == END_MARK) ? 8'h24 : b;
    endfunction

    function automatic void push_header(input int h);
        logic [23:0] hdr;
        case (h)
            0:       hdr = "HEX";
            1:       hdr = "DEG";
            2:       hdr = "SRV";
            3:       hdr = "SRT";
            4:       hdr = "SS8";
            default: hdr = {"LE", plain_byte()};
        endcase
        msg_q.push_back(hdr[23:16]);
        msg_q.push_back(hdr[15:8]);
        msg_q.push_back(hdr[7:0]);
    endfunction

    function automatic void build_random_msg();
        int    h;
        int    r;
        int    len;
        string alpha;
        alpha = "HEXDGSRVT8L";
        msg_q.delete();
        if ($urandom_range(0, 99) < 75) begin
            h = $urandom_range(0, 5);
            push_header(h);
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r = $urandom_range(0, 9);
                if (h == 2 || h == 3) begin
                    if (r < 6)       msg_q.push_back(8'("0" + $urandom_range(0, 9)));
                    else if (r == 6) msg_q.push_back(" ");
                    else if (r == 7) msg_q.push_back(8'($urandom_range(9, 13)));
                    else if (r == 8) msg_q.push_back($urandom_range(0, 1) ? "+" : "-");
                    else             msg_q.push_back(plain_byte());
                end else if (h == 4) begin
                    if (r < 8) msg_q.push_back(hex_set[$urandom_range(0, 21)]);
                    else       msg_q.push_back(plain_byte());
                end else begin
                    msg_q.push_back(plain_byte());
                end
            end
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    len = $urandom_range(0, 30);
                    for (int i = 0; i < len; i++)
                        msg_q.push_back(($urandom_range(0, 9) == 0) ? END_MARK
                                                                    : 8'($urandom_range(0, 255)));
                end
                1: begin
                    // right header, wrong length
                    push_header($urandom_range(0, 5));
                    len = $urandom_range(0, 1) ? 15 : 17;
                    for (int i = 0; i < len; i++) msg_q.push_back(plain_byte());
                end
                2: begin
                    // near-miss headers
                    for (int i = 0; i < 3; i++) msg_q.push_back(alpha[$urandom_range(0, 10)]);
                    for (int i = 0; i < NUM_CHANNELS; i++) msg_q.push_back(plain_byte());
                end
                default: begin
                    // run past the text limit, then a frame
                    len = $urandom_range(60, 70);
                    for (int i = 0; i < len; i++) msg_q.push_back(plain_byte());
                    push_header($urandom_range(0, 1));
                    for (int i = 0; i < NUM_CHANNELS; i++) msg_q.push_back(plain_byte());
                end
            endcase
        end
        msg_q.push_back(END_MARK);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed);
        while (!calm && $urandom_range(0, 99) < 35) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        parse_rx_byte(b);
        if (!typed)
            foreach (fresh_words[i]) chan_words_q.push_back(fresh_words[i]);
        fresh_words.delete();
    endtask

    task automatic send_msg(input bit typed);
        foreach (msg_q[i]) send_byte(msg_q[i], typed);
    endtask

    // sender stops until all words are out and the decoder has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (chan_words_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_neutral(input logic [NEU_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_NEUTRAL, 2'b00};
        pwdata  <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== 32'(v)) begin
            $display("%0t neutral readback: expected %0d, got %0d", $time, v, prdata);
            err_cnt++;
        end
        psel        <= 1'b0;
        penable     <= 1'b0;
        neutral_cfg  = v;
    endtask

    // ---------------- receive side and checker ----------------

    always @(posedge i_clk) begin : rx_side
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_tready) begin
            got.channel = m_axis_tdata[3:0];
            got.value   = m_axis_tdata[16:4];
            got.kind    = t_kind'(m_axis_tuser);
            got.last    = m_axis_tlast;
            words_seen++;
            if (chan_words_q.size() == 0) begin
                $display("%0t unexpected word: ch %0d value %0d kind %0d last %0b", $time,
                         got.channel, $signed(got.value), got.kind, got.last);
                err_cnt++;
            end else begin
                want = chan_words_q.pop_front();
                if (got.channel !== want.channel || got.value !== want.value ||
                    got.kind !== want.kind || got.last !== want.last) begin
                    $display("%0t mismatch: expected ch %0d value %0d kind %0d last %0b, got ch %0d value %0d kind %0d last %0b",
                             $time, want.channel, $signed(want.value), want.kind, want.last,
                             got.channel, $signed(got.value), got.kind, got.last);
                    err_cnt++;
                end
            end
        end
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && words_seen >= HOLD_AT) begin
            // one long hold-off so the block backs up into its input
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYC;
            hold_done <= 1'b1;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_tready) || (psel && penable)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t no progress for %0d cycles, %0d words outstanding", $time, quiet,
                     chan_words_q.size());
            $display("[rc_channel_frame_parser_unit] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ---------------- main sequence ----------------

    initial begin : stim
        t_row       row;
        bit         started;
        logic [7:0] b;

        //               pre_b  pre  text                     pad_b  pad  neu   typed val   kind
        dir_rows[0]  = '{8'h00, 0,  "LEx",                   "x",   16,  -1,   1,    0,    K_LED};
        dir_rows[1]  = '{8'h00, 0,  "HEX",                   8'h00, 16,  -1,   16,   0,    K_HEX};
        dir_rows[2]  = '{8'h00, 0,  "HEX",                   8'hFF, 16,  -1,   16,   2550, K_HEX};
        dir_rows[3]  = '{8'h00, 0,  "DEG",                   8'h00, 16,  -1,   16,   -127, K_DEG};
        dir_rows[4]  = '{8'h00, 0,  "DEG",                   8'hFF, 16,  -1,   16,   128,  K_DEG};
        dir_rows[5]  = '{8'h00, 0,  "SRV30009999-500 +42",   8'h00, 0,   -1,   -1,   0,    K_SRV};
        dir_rows[6]  = '{8'h00, 0,  "SRT\t\n 5 7x9+-12    ", 8'h00, 0,   -1,   -1,   0,    K_SRV};
        dir_rows[7]  = '{8'h00, 0,  "SS8FFff00a9G1zz7B0c",   8'h00, 0,   3000, -1,   0,    K_SS8};
        dir_rows[8]  = '{8'h00, 0,  "XYZ",                   "A",   16,  -1,   0,    0,    K_HEX};
        dir_rows[9]  = '{8'h00, 0,  "HEX",                   "A",   15,  -1,   0,    0,    K_HEX};
        dir_rows[10] = '{8'h00, 0,  "HEX",                   "A",   17,  -1,   0,    0,    K_HEX};
        dir_rows[11] = '{8'h00, 0,  "HEX12#",                "A",   13,  -1,   0,    0,    K_HEX};
        dir_rows[12] = '{"Z",   64, "HEX",                   "A",   16,  -1,   -1,   0,    K_HEX};
        dir_rows[13] = '{8'h00, 0,  "SRV",                   " ",   16,  0,    -1,   0,    K_SRV};
        dir_rows[14] = '{8'h00, 0,  "",                      8'h00, 0,   -1,   0,    0,    K_HEX};
        dir_rows[15] = '{8'h00, 0,  "DEG",                   8'h7F, 16,  -1,   16,   0,    K_DEG};

        rx_count    = 0;
        neutral_cfg = NEUTRAL_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_ROWS; r++) begin
            row = dir_rows[r];
            if (row.neutral >= 0) begin
                settle();
                write_neutral(NEU_W'(row.neutral));
            end
            msg_q.delete();
            for (int i = 0; i < row.pre_len; i++) msg_q.push_back(row.pre_byte);
            started = 0;
            for (int k = 19; k >= 0; k--) begin
                b = row.text[8*k +: 8];
                if (started || b != 8'h00) begin
                    msg_q.push_back(b);
                    started = 1;
                end
            end
            for (int i = 0; i < row.pad_len; i++) msg_q.push_back(row.pad_byte);
            msg_q.push_back(END_MARK);
            send_msg(row.n_typed >= 0);
            for (int i = 0; i < row.n_typed; i++)
                chan_words_q.push_back('{4'(i), 13'(row.t_val), row.t_knd,
                                        1'(i == row.n_typed - 1)});
        end

        for (int m = 0; m < RAND_MSGS; m++) begin
            calm = (m >= 40 && m < 60);
            if (m % 25 == 12) begin
                settle();
                write_neutral(NEU_W'($urandom_range(0, int'(PULSE_MAX))));
            end
            build_random_msg();
            send_msg(1'b0);
        end

        s_tvalid <= 1'b0;
        while (chan_words_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0)
            $display("[rc_channel_frame_parser_unit] OK");
        else
            $display("[rc_channel_frame_parser_unit] ERROR");
        $finish;
    end

endmodule
